FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define RDF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: design/rdf_pkg.sv
`timescale 1ns / 1ps
package rdf_pkg;

  localparam int unsigned MdProdW = 24;

  typedef struct packed {
    logic        start;
    logic [15:0] a;
    logic [7:0]  b;
    logic [15:0] d;
  } md_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] q;
    logic       rem_nz;
  } md_rsp_t;

  localparam logic [2:0] ActSensor   = 3'd0;
  localparam logic [2:0] ActTick     = 3'd1;
  localparam logic [2:0] ActRender   = 3'd2;
  localparam logic [2:0] ActOvrSet   = 3'd3;
  localparam logic [2:0] ActOvrClear = 3'd4;

  localparam logic [2:0] RegMinDist = 3'd0;
  localparam logic [2:0] RegMaxDist = 3'd1;
  localparam logic [2:0] RegMinLvl  = 3'd2;
  localparam logic [2:0] RegMaxLvl  = 3'd3;
  localparam logic [2:0] RegAmbEn   = 3'd4;
  localparam logic [2:0] RegGammaEn = 3'd5;
  localparam logic [2:0] RegFadeMs  = 3'd6;

  localparam logic [7:0] GAMMA_LUT [256] = '{
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,
    8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
    8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd6,8'd6,8'd6,
    8'd6,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,
    8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,8'd17,8'd17,8'd18,8'd18,
    8'd19,8'd19,
    8'd20,8'd20,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd25,8'd25,8'd26,8'd26,8'd27,8'd28,
    8'd28,8'd29,
    8'd30,8'd30,8'd31,8'd32,8'd33,8'd33,8'd34,8'd35,8'd35,8'd36,8'd37,8'd38,8'd39,8'd39,
    8'd40,8'd41,
    8'd42,8'd43,8'd43,8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,8'd49,8'd50,8'd51,8'd52,8'd53,
    8'd54,8'd55,
    8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd65,8'd66,8'd67,8'd68,8'd69,
    8'd70,8'd71,
    8'd73,8'd74,8'd75,8'd76,8'd77,8'd78,8'd79,8'd81,8'd82,8'd83,8'd84,8'd85,8'd87,8'd88,
    8'd89,8'd90,
    8'd91,8'd93,8'd94,8'd95,8'd97,8'd98,8'd99,8'd100,8'd102,8'd103,8'd105,8'd106,8'd107,
    8'd109,8'd110,8'd111,
    8'd113,8'd114,8'd116,8'd117,8'd119,8'd120,8'd121,8'd123,8'd124,8'd126,8'd127,8'd129,
    8'd130,8'd132,8'd133,8'd135,
    8'd137,8'd138,8'd140,8'd141,8'd143,8'd145,8'd146,8'd148,8'd149,8'd151,8'd153,8'd154,
    8'd156,8'd158,8'd159,8'd161,
    8'd163,8'd165,8'd166,8'd168,8'd170,8'd172,8'd173,8'd175,8'd177,8'd179,8'd181,8'd182,
    8'd184,8'd186,8'd188,8'd190,
    8'd192,8'd194,8'd196,8'd197,8'd199,8'd201,8'd203,8'd205,8'd207,8'd209,8'd211,8'd213,
    8'd215,8'd217,8'd219,8'd221,
    8'd223,8'd225,8'd227,8'd229,8'd231,8'd234,8'd236,8'd238,8'd240,8'd242,8'd244,8'd246,
    8'd248,8'd251,8'd253,8'd255
  };

endpackage

FILE: design/rdf_muldiv.sv
`timescale 1ns / 1ps
// Serial floor(a*b/d): shift-add multiply one bit of b per cycle,
// then restoring division one quotient bit per cycle.
module rdf_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rdf_pkg::md_req_t req_i,
  output rdf_pkg::md_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        div_q, div_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [rdf_pkg::MdProdW-1:0] acc_q, acc_d;
  logic [rdf_pkg::MdProdW-1:0] mc_q, mc_d;
  logic [7:0]  b_q, b_d;
  logic [15:0] d_q, d_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, acc_q[rdf_pkg::MdProdW-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = (trial >= {1'b0, d_q});

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    b_d    = b_q;
    d_d    = d_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = 1'b0;
      cnt_d  = 5'd0;
      acc_d  = '0;
      mc_d   = {8'd0, req_i.a};
      b_d    = req_i.b;
      d_d    = req_i.d;
      rem_d  = '0;
    end else if (busy_q && !div_q) begin
      // accumulate one multiplier bit
      if (b_q[0]) acc_d = acc_q + mc_q;
      mc_d  = {mc_q[rdf_pkg::MdProdW-2:0], 1'b0};
      b_d   = {1'b0, b_q[7:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd7) begin
        div_d = 1'b1;
        cnt_d = 5'd0;
      end
    end else if (busy_q) begin
      // develop one quotient bit
      rem_d = ge ? diff[15:0] : trial[15:0];
      acc_d = {acc_q[rdf_pkg::MdProdW-2:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(rdf_pkg::MdProdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    b_q   <= b_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.q      = acc_q[7:0];
  assign rsp_o.rem_nz = |rem_q;

endmodule

FILE: design/rgb_distance_fade_driver_unit.sv
`timescale 1ns / 1ps
// RGB LED driver fed by a distance sensor and an ambient light sensor. One item
// is worked on at a time; every scaled quantity goes through one shared serial
// multiply-divide unit (8 multiply steps and 24 quotient steps per operation).
// Tick and override items finish in IDLE; a sensor update runs the window
// mapping (skipped under override) and the ambient level; a render runs up to
// three fade interpolations and three brightness scalings, and its duties then
// sit in an output register while the next item is already taken.
// Configuration writes are taken at any time, one per cycle.
module rgb_distance_fade_driver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] distance_q4_i,
  input  logic [11:0] light_raw_i,
  input  logic [23:0] set_colour_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  duty_red_o,
  output logic [7:0]  duty_green_o,
  output logic [7:0]  duty_blue_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIST      = 4'd1;
  localparam logic [3:0] S_DIST_WAIT = 4'd2;
  localparam logic [3:0] S_LVL       = 4'd3;
  localparam logic [3:0] S_LVL_WAIT  = 4'd4;
  localparam logic [3:0] S_CMP       = 4'd5;
  localparam logic [3:0] S_FADE      = 4'd6;
  localparam logic [3:0] S_FADE_GO   = 4'd7;
  localparam logic [3:0] S_FADE_WAIT = 4'd8;
  localparam logic [3:0] S_SCL_GO    = 4'd9;
  localparam logic [3:0] S_SCL_WAIT  = 4'd10;
  localparam logic [3:0] S_EMIT      = 4'd11;

  // configuration
  logic [15:0] min_dist_q, max_dist_q, fade_ms_q;
  logic [7:0]  min_lvl_q, max_lvl_q;
  logic        amb_en_q, gamma_en_q;

  // block state
  logic [3:0]  state_q, state_d;
  logic [1:0]  ch_q, ch_d;
  logic        ovr_q, ovr_d;
  logic [23:0] target_q, target_d;
  logic [23:0] shown_q, shown_d;
  logic [23:0] origin_q, origin_d;
  logic [7:0]  level_q, level_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic        running_q, running_d;
  logic [15:0] dist_q, dist_d;
  logic [11:0] light_q, light_d;
  logic [7:0]  work_q [3];
  logic [7:0]  work_d [3];
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_r_q, out_g_q, out_b_q;
  logic [7:0]  out_r_d, out_g_d, out_b_d;

  rdf_pkg::md_req_t md_req;
  rdf_pkg::md_rsp_t md_rsp;

  logic [7:0]  from_c, to_c, delta_c, shown_c, lvl_diff, scaled;
  logic        up_c, lvl_up;
  logic [11:0] dark;
  logic        md_wait, emit_fire;

  rdf_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // channel 0 is red, 1 green, 2 blue
  always_comb begin
    unique case (ch_q)
      2'd0: begin
        from_c  = origin_q[23:16];
        to_c    = target_q[23:16];
        shown_c = shown_q[23:16];
      end
      2'd1: begin
        from_c  = origin_q[15:8];
        to_c    = target_q[15:8];
        shown_c = shown_q[15:8];
      end
      default: begin
        from_c  = origin_q[7:0];
        to_c    = target_q[7:0];
        shown_c = shown_q[7:0];
      end
    endcase
  end

  assign up_c     = (to_c >= from_c);
  assign delta_c  = up_c ? (to_c - from_c) : (from_c - to_c);
  assign lvl_up   = (max_lvl_q >= min_lvl_q);
  assign lvl_diff = lvl_up ? (max_lvl_q - min_lvl_q) : (min_lvl_q - max_lvl_q);
  assign dark     = 12'hFFF - light_q;
  assign scaled   = gamma_en_q ? rdf_pkg::GAMMA_LUT[md_rsp.q] : md_rsp.q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    ovr_d       = ovr_q;
    target_d    = target_q;
    shown_d     = shown_q;
    origin_d    = origin_q;
    level_d     = level_q;
    elapsed_d   = elapsed_q;
    running_d   = running_q;
    dist_d      = dist_q;
    light_d     = light_q;
    work_d      = work_q;
    out_valid_d = out_valid_q;
    out_r_d     = out_r_q;
    out_g_d     = out_g_q;
    out_b_d     = out_b_q;
    md_req      = '0;

    // drop the result once the sink takes it
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dist_d  = distance_q4_i;
          light_d = light_raw_i;
          unique case (action_i)
            rdf_pkg::ActSensor:   state_d = ovr_q ? S_LVL : S_DIST;
            rdf_pkg::ActTick: begin
              if (elapsed_q != 16'hFFFF) elapsed_d = elapsed_q + 16'd1;
            end
            rdf_pkg::ActRender:   state_d = S_FADE;
            rdf_pkg::ActOvrSet: begin
              ovr_d     = 1'b1;
              target_d  = set_colour_i;
              origin_d  = shown_q;
              elapsed_d = '0;
              running_d = 1'b1;
            end
            rdf_pkg::ActOvrClear: ovr_d = 1'b0;
            default: ;
          endcase
        end
      end
      S_DIST: begin
        // map distance onto the red/blue window
        priority if (dist_q <= min_dist_q) begin
          target_d = 24'hFF0000;
          state_d  = S_LVL;
        end else if (dist_q >= max_dist_q) begin
          target_d = 24'h0000FF;
          state_d  = S_LVL;
        end else begin
          md_req.start = 1'b1;
          md_req.a     = dist_q - min_dist_q;
          md_req.b     = 8'hFF;
          md_req.d     = max_dist_q - min_dist_q;
          state_d      = S_DIST_WAIT;
        end
      end
      S_DIST_WAIT: begin
        if (md_rsp.done) begin
          // red = 255 - ceil(255n/w)
          target_d = {8'hFF - md_rsp.q - {7'd0, md_rsp.rem_nz}, 8'd0, md_rsp.q};
          state_d  = S_LVL;
        end
      end
      S_LVL: begin
        if (!amb_en_q) begin
          level_d = max_lvl_q;
          state_d = S_CMP;
        end else begin
          md_req.start = 1'b1;
          md_req.a     = {4'd0, dark};
          md_req.b     = lvl_diff;
          md_req.d     = 16'd4095;
          state_d      = S_LVL_WAIT;
        end
      end
      S_LVL_WAIT: begin
        if (md_rsp.done) begin
          level_d = lvl_up ? (min_lvl_q + md_rsp.q) : (min_lvl_q - md_rsp.q);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (target_q != origin_q) begin
          origin_d  = shown_q;
          elapsed_d = '0;
          running_d = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_FADE: begin
        ch_d = 2'd0;
        if (running_q && (elapsed_q < fade_ms_q)) begin
          state_d = S_FADE_GO;
        end else begin
          running_d = 1'b0;
          shown_d   = target_q;
          state_d   = S_SCL_GO;
        end
      end
      S_FADE_GO: begin
        md_req.start = 1'b1;
        md_req.a     = elapsed_q;
        md_req.b     = delta_c;
        md_req.d     = fade_ms_q;
        state_d      = S_FADE_WAIT;
      end
      S_FADE_WAIT: begin
        if (md_rsp.done) begin
          unique case (ch_q)
            2'd0:    shown_d[23:16] = up_c ? (from_c + md_rsp.q) : (from_c - md_rsp.q);
            2'd1:    shown_d[15:8]  = up_c ? (from_c + md_rsp.q) : (from_c - md_rsp.q);
            default: shown_d[7:0]   = up_c ? (from_c + md_rsp.q) : (from_c - md_rsp.q);
          endcase
          if (ch_q == 2'd2) begin
            ch_d    = 2'd0;
            state_d = S_SCL_GO;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = S_FADE_GO;
          end
        end
      end
      S_SCL_GO: begin
        md_req.start = 1'b1;
        md_req.a     = {8'd0, shown_c};
        md_req.b     = level_q;
        md_req.d     = 16'd255;
        state_d      = S_SCL_WAIT;
      end
      S_SCL_WAIT: begin
        if (md_rsp.done) begin
          work_d[ch_q] = scaled;
          if (ch_q == 2'd2) begin
            ch_d    = 2'd0;
            state_d = S_EMIT;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = S_SCL_GO;
          end
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_r_d     = work_q[0];
          out_g_d     = work_q[1];
          out_b_d     = work_q[2];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q  <= 16'd80;
      max_dist_q  <= 16'd1600;
      min_lvl_q   <= 8'd0;
      max_lvl_q   <= 8'd255;
      amb_en_q    <= 1'b1;
      gamma_en_q  <= 1'b1;
      fade_ms_q   <= 16'd250;
      state_q     <= S_IDLE;
      ch_q        <= 2'd0;
      ovr_q       <= 1'b0;
      target_q    <= '0;
      shown_q     <= '0;
      origin_q    <= '0;
      level_q     <= '0;
      elapsed_q   <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rdf_pkg::RegMinDist: min_dist_q <= cfg_data_i;
          rdf_pkg::RegMaxDist: max_dist_q <= cfg_data_i;
          rdf_pkg::RegMinLvl:  min_lvl_q  <= cfg_data_i[7:0];
          rdf_pkg::RegMaxLvl:  max_lvl_q  <= cfg_data_i[7:0];
          rdf_pkg::RegAmbEn:   amb_en_q   <= cfg_data_i[0];
          rdf_pkg::RegGammaEn: gamma_en_q <= cfg_data_i[0];
          rdf_pkg::RegFadeMs:  fade_ms_q  <= cfg_data_i;
          default: ;
        endcase
      end
      state_q     <= state_d;
      ch_q        <= ch_d;
      ovr_q       <= ovr_d;
      target_q    <= target_d;
      shown_q     <= shown_d;
      origin_q    <= origin_d;
      level_q     <= level_d;
      elapsed_q   <= elapsed_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    light_q <= light_d;
    work_q  <= work_d;
    out_r_q <= out_r_d;
    out_g_q <= out_g_d;
    out_b_q <= out_b_d;
  end

  assign out_valid_o  = out_valid_q;
  assign duty_red_o   = out_r_q;
  assign duty_green_o = out_g_q;
  assign duty_blue_o  = out_b_q;

  assign md_wait   = (state_q == S_DIST_WAIT) || (state_q == S_LVL_WAIT) ||
                     (state_q == S_FADE_WAIT) || (state_q == S_SCL_WAIT);
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  `RDF_ASSERT(a_md_done_in_wait, md_rsp.done |-> md_wait, "muldiv result outside a wait state")
  `RDF_ASSERT(a_emit_loads, emit_fire |=> (out_valid_q && state_q == S_IDLE), "render result lost")
  `RDF_NEVER(a_ch_range, ch_q == 2'd3, "channel index out of range")

endmodule
